@@ design/smf_pkg.sv @@
// ----------------------------------------------------------------------------
// smf_pkg: shared types for the sliding median filter
// Sample and item types, the configuration width and reset value, and the
// command set of the sorted cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smf_pkg;

  // Sample width of the Q16.16 data path.
  localparam int unsigned SAMPLE_BITS = 32;

  // Window size register.
  localparam int unsigned            CFG_BITS     = 5;
  localparam logic [CFG_BITS-1:0]    WINDOW_RESET = 5'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Input item: one sample and the end-of-sequence mark.
  typedef struct packed {
    sample_t sample;
    logic    last_in;
  } in_item_t;

  // Result item: one median and the end-of-sequence mark.
  typedef struct packed {
    sample_t median;
    logic    last_out;
  } out_item_t;

  // Commands of the sorted cell chain.
  typedef enum logic [2:0] {
    CH_HOLD   = 3'd0,  // keep contents
    CH_FILL   = 3'd1,  // load one value into the whole active window
    CH_CLEAR  = 3'd2,  // empty every cell
    CH_SLIDE  = 3'd3,  // drop the oldest entry, age the rest, insert a new one
    CH_INSERT = 3'd4   // insert one entry with a given age, nothing dropped
  } chain_op_e;

  typedef struct packed {
    chain_op_e op;
    sample_t   key;
  } chain_ctl_t;

endpackage

@@ design/smf_ring.sv @@
// ----------------------------------------------------------------------------
// smf_ring: sample history line
// A row of sample registers, newest at the head. New samples shift in at
// the head; a rotate moves every entry one place toward the head so that the
// history can be read out through the head and restored after a full turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smf_ring
  import smf_pkg::*;
#(
  parameter int unsigned DEPTH = 31
) (
  input  logic    clk_i,
  input  logic    shift_i,
  input  logic    rot_i,
  input  sample_t din_i,
  output sample_t head_o
);

  sample_t ring_q [DEPTH];
  sample_t ring_d [DEPTH];

  // Next contents: shift toward the old end, or rotate toward the head.
  always_comb begin
    ring_d = ring_q;
    if (shift_i) begin
      ring_d[0] = din_i;
      for (int i = 1; i < DEPTH; i++) begin
        ring_d[i] = ring_q[i-1];
      end
    end else if (rot_i) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ring_d[i] = ring_q[i+1];
      end
      ring_d[DEPTH-1] = ring_q[0];
    end
  end

  // Payload storage, no reset.
  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
  end

  assign head_o = ring_q[0];

endmodule

@@ design/smf_sort_cell.sv @@
// ----------------------------------------------------------------------------
// smf_sort_cell: one cell of the sorted window chain
// Holds one window entry (valid, sample, age). The chain stays sorted in
// ascending order; each cell works out its own next entry from its left and
// right neighbors, so a delete and an insert take effect together.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smf_sort_cell
  import smf_pkg::*;
#(
  parameter int unsigned TAG_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chain_ctl_t       ctl_i,
  input  logic [TAG_W-1:0] ins_tag_i,
  input  logic [TAG_W-1:0] span_i,
  // Delete point already passed on the left.
  input  logic             past_i,
  // Left neighbor after its delete step, and its compare result.
  input  logic             lft_vld_i,
  input  sample_t          lft_key_i,
  input  logic [TAG_W-1:0] lft_tag_i,
  input  logic             lft_le_i,
  // Right neighbor's stored entry.
  input  logic             rgt_vld_i,
  input  sample_t          rgt_key_i,
  input  logic [TAG_W-1:0] rgt_tag_i,
  // Stored entry.
  output logic             vld_o,
  output sample_t          key_o,
  output logic [TAG_W-1:0] tag_o,
  // This cell after the delete step, for the right neighbor.
  output logic             l_vld_o,
  output sample_t          l_key_o,
  output logic [TAG_W-1:0] l_tag_o,
  output logic             le_o,
  output logic             past_o
);

  localparam logic [TAG_W-1:0] IDX_T = IDX[TAG_W-1:0];

  logic             vld_q, vld_d;
  sample_t          key_q, key_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic             slide;
  logic             hit;
  logic             sel_vld;
  sample_t          sel_key;
  logic [TAG_W-1:0] sel_tag;
  logic             ins_vld;
  sample_t          ins_key;
  logic [TAG_W-1:0] ins_tag;

  // Delete step: cells at or right of the dropped entry take their right
  // neighbor; on a slide every surviving entry grows one older.
  always_comb begin
    slide   = (ctl_i.op == CH_SLIDE);
    hit     = slide && vld_q && (tag_q == span_i);
    past_o  = past_i | hit;
    sel_vld = past_o ? rgt_vld_i : vld_q;
    sel_key = past_o ? rgt_key_i : key_q;
    sel_tag = past_o ? rgt_tag_i : tag_q;
    l_vld_o = sel_vld;
    l_key_o = sel_key;
    l_tag_o = slide ? sel_tag + TAG_W'(1) : sel_tag;
    // An empty cell sorts above every sample.
    le_o    = l_vld_o && (l_key_o <= ctl_i.key);
  end

  // Insert step: keep, take the new entry, or take the left neighbor.
  always_comb begin
    ins_tag = slide ? '0 : ins_tag_i;
    if (le_o) begin
      ins_vld = l_vld_o;
      ins_key = l_key_o;
      ins_tag = l_tag_o;
    end else if (lft_le_i) begin
      ins_vld = 1'b1;
      ins_key = ctl_i.key;
    end else begin
      ins_vld = lft_vld_i;
      ins_key = lft_key_i;
      ins_tag = lft_tag_i;
    end
  end

  // Command decode.
  always_comb begin
    vld_d = vld_q;
    key_d = key_q;
    tag_d = tag_q;
    case (ctl_i.op)
      CH_FILL: begin
        vld_d = (IDX_T <= span_i);
        key_d = ctl_i.key;
        tag_d = IDX_T;
      end
      CH_CLEAR: begin
        vld_d = 1'b0;
      end
      CH_SLIDE, CH_INSERT: begin
        vld_d = ins_vld;
        key_d = ins_key;
        tag_d = ins_tag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign vld_o = vld_q;
  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

@@ design/smf_sort_chain.sv @@
// ----------------------------------------------------------------------------
// smf_sort_chain: sorted window of samples
// A row of sort cells that keeps the current window in ascending order with
// an age on every entry, and taps the median at the selected rank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smf_sort_chain
  import smf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 31,
  parameter int unsigned TAG_W      = 5,
  parameter int unsigned HW         = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chain_ctl_t       ctl_i,
  input  logic [TAG_W-1:0] ins_tag_i,
  input  logic [TAG_W-1:0] span_i,
  input  logic [HW-1:0]    sel_i,
  output sample_t          med_o
);

  localparam int unsigned HMAX = (MAX_WINDOW - 1) / 2;

  // Stored entries; the extra slot past the end reads as empty.
  logic             e_vld [MAX_WINDOW+1];
  sample_t          e_key [MAX_WINDOW+1];
  logic [TAG_W-1:0] e_tag [MAX_WINDOW+1];
  // Entries after the delete step, handed to the right; slot 0 is the edge.
  logic             l_vld [MAX_WINDOW+1];
  sample_t          l_key [MAX_WINDOW+1];
  logic [TAG_W-1:0] l_tag [MAX_WINDOW+1];
  logic             l_le  [MAX_WINDOW+1];
  logic             past  [MAX_WINDOW+1];

  assign e_vld[MAX_WINDOW] = 1'b0;
  assign e_key[MAX_WINDOW] = '0;
  assign e_tag[MAX_WINDOW] = '0;
  assign l_vld[0]          = 1'b0;
  assign l_key[0]          = '0;
  assign l_tag[0]          = '0;
  assign l_le[0]           = 1'b1;
  assign past[0]           = 1'b0;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    smf_sort_cell #(
      .TAG_W (TAG_W),
      .IDX   (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_i),
      .ins_tag_i (ins_tag_i),
      .span_i    (span_i),
      .past_i    (past[k]),
      .lft_vld_i (l_vld[k]),
      .lft_key_i (l_key[k]),
      .lft_tag_i (l_tag[k]),
      .lft_le_i  (l_le[k]),
      .rgt_vld_i (e_vld[k+1]),
      .rgt_key_i (e_key[k+1]),
      .rgt_tag_i (e_tag[k+1]),
      .vld_o     (e_vld[k]),
      .key_o     (e_key[k]),
      .tag_o     (e_tag[k]),
      .l_vld_o   (l_vld[k+1]),
      .l_key_o   (l_key[k+1]),
      .l_tag_o   (l_tag[k+1]),
      .le_o      (l_le[k+1]),
      .past_o    (past[k+1])
    );
  end

  // The median of a window of 2h+1 entries sits in cell h.
  always_comb begin
    med_o = e_key[0];
    for (int k = 0; k <= HMAX; k++) begin
      if (sel_i == HW'(k)) begin
        med_o = e_key[k];
      end
    end
  end

endmodule

@@ design/sliding_median_filter.sv @@
// ----------------------------------------------------------------------------
// sliding_median_filter: running median over a centered odd window
// A passthrough result goes straight into the output register; a median
// goes through the sorted chain update, then the output register.
// Throughput: one sample per cycle unless the output stalls, as the chain
// deletes and inserts at once; the last sample flushes one result per cycle
// unless the output stalls; a window change in a sequence forces a rebuild.
// Reset: window size 5, empty sequence; the sample history is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_median_filter
  import smf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Sample stream.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  // Result stream.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  // Window size register.
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned TAG_W = $clog2(MAX_WINDOW);
  localparam int unsigned HMAX  = (MAX_WINDOW - 1) / 2;
  localparam int unsigned HW    = $clog2(HMAX + 1);
  localparam int unsigned CW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WW    = ((CW > CFG_BITS) ? CW : CFG_BITS) + 1;
  localparam logic [TAG_W-1:0] A_LAST = TAG_W'(MAX_WINDOW - 1);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_REBUILD = 3'b010,
    ST_EMIT    = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [CFG_BITS-1:0]   cfg_q;
  logic [CW-1:0]         count_q, count_d;
  sample_t               first_q, first_d;
  logic [CW-1:0]         c_q, c_d;
  logic                  last_q, last_d;
  logic [HW-1:0]         h_q, h_d;
  logic [HW-1:0]         d_q, d_d;
  logic [TAG_W-1:0]      a_q, a_d;
  logic                  chain_ok_q, chain_ok_d;
  logic [HW-1:0]         chain_h_q, chain_h_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;
  logic                  out_load;

  logic [WW-1:0]         w_odd, w_cut, w_eff;
  logic [HW-1:0]         h_cfg;
  logic [TAG_W-1:0]      span;
  logic [TAG_W-1:0]      span_q;
  logic                  slot_free;
  logic                  emit_now;
  logic                  step_done;
  logic                  step_ok;
  logic                  take;
  chain_ctl_t            ctl;
  logic [TAG_W-1:0]      ins_tag;
  logic                  ring_shift;
  logic                  ring_rot;
  sample_t               ring_head;
  sample_t               med;

  // Effective half window: even sizes round up, then cut to an odd size that
  // fits the history.
  always_comb begin
    w_odd = cfg_q[0] ? WW'(cfg_q) : WW'(cfg_q) + WW'(1);
    w_cut = (w_odd > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : w_odd;
    w_eff = w_cut[0] ? w_cut : w_cut - WW'(1);
    h_cfg = HW'(w_eff >> 1);
  end

  assign span_q = TAG_W'({h_q, 1'b0});
  assign span   = take ? TAG_W'({h_cfg, 1'b0}) : span_q;

  // Handshake: the output register frees when its result is taken.
  assign slot_free = !out_valid_q || out_ready_i;
  assign emit_now  = (c_q >= CW'(d_q));
  assign step_done = !(last_q && (d_q != '0));
  assign step_ok   = !emit_now || slot_free;

  always_comb begin
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = (h_cfg != '0) || slot_free;
      end
      ST_EMIT: begin
        in_ready_o = step_done && step_ok && (h_cfg != '0);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign take = in_valid_i && in_ready_o;

  // Sequencer: accept, rebuild after a window change, emit and flush.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    first_d    = first_q;
    c_d        = c_q;
    last_d     = last_q;
    h_d        = h_q;
    d_d        = d_q;
    a_d        = a_q;
    chain_ok_d = chain_ok_q;
    chain_h_d  = chain_h_q;
    out_load   = 1'b0;
    out_d      = out_q;
    ctl.op     = CH_HOLD;
    ctl.key    = ring_head;
    ins_tag    = '0;
    ring_shift = 1'b0;
    ring_rot   = 1'b0;

    case (state_q)
      ST_REBUILD: begin
        // Read the history through the head, one age a cycle; ages beyond
        // the sequence start take the first sample.
        ring_rot = 1'b1;
        if (a_q <= span_q) begin
          ctl.op  = CH_INSERT;
          ctl.key = (CW'(a_q) <= c_q) ? ring_head : first_q;
          ins_tag = a_q;
        end
        a_d = a_q + TAG_W'(1);
        if (a_q == A_LAST) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (step_ok) begin
          if (emit_now) begin
            out_load       = 1'b1;
            out_d.median   = med;
            out_d.last_out = last_q && (d_q == '0);
          end
          if (!step_done) begin
            // Flush: slide the last sample in once more.
            ctl.op  = CH_SLIDE;
            ctl.key = ring_head;
            d_d     = d_q - HW'(1);
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
      end
    endcase

    // New sample transfer.
    if (take) begin
      ring_shift = 1'b1;
      if (count_q == '0) begin
        first_d = in_data_i.sample;
      end
      if (in_data_i.last_in) begin
        count_d = '0;
      end else if (count_q < CW'(MAX_WINDOW)) begin
        count_d = count_q + CW'(1);
      end
      if (h_cfg == '0) begin
        out_load       = 1'b1;
        out_d.median   = in_data_i.sample;
        out_d.last_out = in_data_i.last_in;
        chain_ok_d     = 1'b0;
        state_d        = ST_IDLE;
      end else begin
        c_d    = count_q;
        last_d = in_data_i.last_in;
        h_d    = h_cfg;
        d_d    = h_cfg;
        if (count_q == '0) begin
          ctl.op     = CH_FILL;
          ctl.key    = in_data_i.sample;
          chain_ok_d = 1'b1;
          chain_h_d  = h_cfg;
          state_d    = ST_EMIT;
        end else if (!chain_ok_q || (chain_h_q != h_cfg)) begin
          ctl.op     = CH_CLEAR;
          a_d        = '0;
          chain_ok_d = 1'b1;
          chain_h_d  = h_cfg;
          state_d    = ST_REBUILD;
        end else begin
          ctl.op  = CH_SLIDE;
          ctl.key = in_data_i.sample;
          state_d = ST_EMIT;
        end
      end
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= WINDOW_RESET;
      count_q     <= '0;
      first_q     <= '0;
      c_q         <= '0;
      last_q      <= 1'b0;
      h_q         <= '0;
      d_q         <= '0;
      a_q         <= '0;
      chain_ok_q  <= 1'b0;
      chain_h_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      first_q     <= first_d;
      c_q         <= c_d;
      last_q      <= last_d;
      h_q         <= h_d;
      d_q         <= d_d;
      a_q         <= a_d;
      chain_ok_q  <= chain_ok_d;
      chain_h_q   <= chain_h_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  smf_ring #(
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .shift_i (ring_shift),
    .rot_i   (ring_rot),
    .din_i   (in_data_i.sample),
    .head_o  (ring_head)
  );

  smf_sort_chain #(
    .MAX_WINDOW (MAX_WINDOW),
    .TAG_W      (TAG_W),
    .HW         (HW)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .ins_tag_i (ins_tag),
    .span_i    (span),
    .sel_i     (h_q),
    .med_o     (med)
  );

endmodule
